### design/ultrasonic_echo_ranger_assert.svh
// Assertion macros for the ultrasonic echo ranger; only the phase sequencer (uer_ctrl) uses them.
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`ifndef SYNTHESIS
`define UER_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ultrasonic echo ranger check failed");
`define UER_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ultrasonic echo ranger sequence check failed");
`else
`define UER_ASSERT(name, prop)
`define UER_ASSERT_NEXT(name, pre, post)
`endif
`endif

### design/uer_pkg.sv
// Package with types, widths and register codes of the ultrasonic echo ranger.
package uer_pkg;

  localparam int CountWidth   = 24;
  localparam int TrigWidth    = 10;
  localparam int HoldWidth    = 24;
  localparam int ScaleWidth   = 16;
  localparam int DistWidth    = 22;
  localparam int CfgIdxWidth  = 2;
  localparam int CfgDataWidth = 24;
  localparam int FracBits     = 16;

  localparam logic [TrigWidth-1:0]  TrigReset  = TrigWidth'(80);
  localparam logic [HoldWidth-1:0]  HoldReset  = HoldWidth'(1600000);
  localparam logic [ScaleWidth-1:0] ScaleReset = ScaleWidth'(14049);
  localparam logic [DistWidth-1:0]  ThrReset   = DistWidth'(10000);

  localparam logic [CfgIdxWidth-1:0] CFG_TRIGGER_TICKS = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_HOLD_TICKS    = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_SCALE_Q16     = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_FAR_THRESHOLD = 2'd3;

  typedef enum logic [1:0] {
    PH_TRIGGER = 2'd0,
    PH_WAIT    = 2'd1,
    PH_COUNT   = 2'd2,
    PH_HOLD    = 2'd3
  } uer_phase_t;

  typedef struct packed {
    logic [TrigWidth-1:0]  trigger_ticks;
    logic [HoldWidth-1:0]  hold_ticks;
    logic [ScaleWidth-1:0] scale_q16;
    logic [DistWidth-1:0]  far_threshold_centi;
  } uer_cfg_t;

  typedef struct packed {
    logic                  trig;
    logic                  done;
    logic [CountWidth-1:0] count;
  } uer_ctrl_t;

endpackage

### design/uer_cfg.sv
// Configuration register bank of the ultrasonic echo ranger.
module uer_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [uer_pkg::CfgIdxWidth-1:0]  cfg_addr,
  input  logic [uer_pkg::CfgDataWidth-1:0] cfg_wdata,
  output uer_pkg::uer_cfg_t                cfg_o
);

  uer_pkg::uer_cfg_t cfg_r;
  uer_pkg::uer_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_addr)
        uer_pkg::CFG_TRIGGER_TICKS:
          cfg_nxt.trigger_ticks = cfg_wdata[uer_pkg::TrigWidth-1:0];
        uer_pkg::CFG_HOLD_TICKS:
          cfg_nxt.hold_ticks = cfg_wdata[uer_pkg::HoldWidth-1:0];
        uer_pkg::CFG_SCALE_Q16:
          cfg_nxt.scale_q16 = cfg_wdata[uer_pkg::ScaleWidth-1:0];
        uer_pkg::CFG_FAR_THRESHOLD:
          cfg_nxt.far_threshold_centi = cfg_wdata[uer_pkg::DistWidth-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_ticks       <= uer_pkg::TrigReset;
      cfg_r.hold_ticks          <= uer_pkg::HoldReset;
      cfg_r.scale_q16           <= uer_pkg::ScaleReset;
      cfg_r.far_threshold_centi <= uer_pkg::ThrReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

### design/uer_ctrl.sv
// Phase sequencer: trigger pulse, echo wait, echo timing and hold.
`include "ultrasonic_echo_ranger_assert.svh"

module uer_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic                           echo,
  input  logic [uer_pkg::TrigWidth-1:0]  trigger_ticks,
  input  logic [uer_pkg::HoldWidth-1:0]  hold_ticks,
  output uer_pkg::uer_ctrl_t             ctrl_o
);

  localparam logic [uer_pkg::CountWidth-1:0] CountMax = '1;

  uer_pkg::uer_phase_t                phase_r;
  uer_pkg::uer_phase_t                phase_nxt;
  logic [uer_pkg::HoldWidth-1:0]      tick_r;
  logic [uer_pkg::HoldWidth-1:0]      tick_nxt;
  logic [uer_pkg::CountWidth-1:0]     echo_count_r;
  logic [uer_pkg::CountWidth-1:0]     echo_count_nxt;
  logic [uer_pkg::HoldWidth-1:0]      tick_inc;

  assign tick_inc = tick_r + uer_pkg::HoldWidth'(1);

  always_comb begin
    phase_nxt      = phase_r;
    tick_nxt       = tick_r;
    echo_count_nxt = echo_count_r;
    unique case (phase_r)
      uer_pkg::PH_TRIGGER: begin
        tick_nxt = tick_inc;
        if (tick_inc >= uer_pkg::HoldWidth'(trigger_ticks)) begin
          phase_nxt = uer_pkg::PH_WAIT;
          tick_nxt  = '0;
        end
      end
      uer_pkg::PH_WAIT: begin
        if (echo) begin
          echo_count_nxt = uer_pkg::CountWidth'(1);
          phase_nxt      = uer_pkg::PH_COUNT;
        end
      end
      uer_pkg::PH_COUNT: begin
        if (echo) begin
          if (echo_count_r != CountMax) begin
            echo_count_nxt = echo_count_r + uer_pkg::CountWidth'(1);
          end
        end else begin
          tick_nxt  = '0;
          phase_nxt = (hold_ticks == '0) ? uer_pkg::PH_TRIGGER : uer_pkg::PH_HOLD;
        end
      end
      uer_pkg::PH_HOLD: begin
        tick_nxt = tick_inc;
        if (tick_inc >= hold_ticks) begin
          phase_nxt = uer_pkg::PH_TRIGGER;
          tick_nxt  = '0;
        end
      end
      default: phase_nxt = uer_pkg::PH_TRIGGER;
    endcase
  end

  always_comb begin
    ctrl_o.trig  = 1'b0;
    ctrl_o.done  = 1'b0;
    ctrl_o.count = echo_count_r;
    unique case (phase_r)
      uer_pkg::PH_TRIGGER: ctrl_o.trig = 1'b1;
      uer_pkg::PH_COUNT:   ctrl_o.done = !echo;
      default: ctrl_o.trig = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= uer_pkg::PH_TRIGGER;
      tick_r       <= '0;
      echo_count_r <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      tick_r       <= tick_nxt;
      echo_count_r <= echo_count_nxt;
    end
  end

  `UER_ASSERT(count_nonzero_a, (phase_r == uer_pkg::PH_COUNT) |-> (echo_count_r != '0))
  `UER_ASSERT(trig_counter_bound_a,
    (phase_r == uer_pkg::PH_TRIGGER) |-> (tick_r[uer_pkg::HoldWidth-1:uer_pkg::TrigWidth] == '0))
  `UER_ASSERT_NEXT(rise_starts_count_a,
    step && (phase_r == uer_pkg::PH_WAIT) && echo,
    (phase_r == uer_pkg::PH_COUNT) && (echo_count_r == uer_pkg::CountWidth'(1)))
  `UER_ASSERT_NEXT(done_leaves_count_a,
    step && ctrl_o.done,
    ((phase_r == uer_pkg::PH_HOLD) || (phase_r == uer_pkg::PH_TRIGGER)) && (tick_r == '0))

endmodule

### design/uer_conv.sv
// Count to distance conversion, saturation and far flag compare.
module uer_conv (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  uer_pkg::uer_ctrl_t              ctrl_i,
  input  logic [uer_pkg::ScaleWidth-1:0]  scale_q16,
  input  logic [uer_pkg::DistWidth-1:0]   far_threshold_centi,
  output logic [uer_pkg::DistWidth-1:0]   dist_nxt,
  output logic                            far_nxt
);

  localparam int ProdWidth  = uer_pkg::CountWidth + uer_pkg::ScaleWidth;
  localparam int RoundWidth = ProdWidth + 1;
  localparam int ShWidth    = RoundWidth - uer_pkg::FracBits;
  localparam logic [RoundWidth-1:0] Half = RoundWidth'(1) << (uer_pkg::FracBits - 1);
  localparam logic [uer_pkg::DistWidth-1:0] DistMax = '1;

  logic [ProdWidth-1:0]          prod;
  logic [RoundWidth-1:0]         rounded;
  logic [ShWidth-1:0]            shifted;
  logic [uer_pkg::DistWidth-1:0] dist_new;
  logic [uer_pkg::DistWidth-1:0] last_dist_r;
  logic                          far_r;

  assign prod    = ProdWidth'(ctrl_i.count) * ProdWidth'(scale_q16);
  assign rounded = RoundWidth'(prod) + Half;
  assign shifted = rounded[RoundWidth-1:uer_pkg::FracBits];

  always_comb begin
    if (shifted > ShWidth'(DistMax)) begin
      dist_new = DistMax;
    end else begin
      dist_new = shifted[uer_pkg::DistWidth-1:0];
    end
  end

  always_comb begin
    dist_nxt = last_dist_r;
    far_nxt  = far_r;
    if (ctrl_i.done) begin
      dist_nxt = dist_new;
      if (dist_new > far_threshold_centi) begin
        far_nxt = 1'b1;
      end else if (dist_new < far_threshold_centi) begin
        far_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_dist_r <= '0;
      far_r       <= 1'b0;
    end else if (step) begin
      last_dist_r <= dist_nxt;
      far_r       <= far_nxt;
    end
  end

endmodule

### design/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger with request handshake and result register.
//
//   Channel   Dir  Handshake               Payload
//   in        in   in_valid / in_ready     in_echo_level
//   out       out  out_valid / out_ready   out_trigger_level, out_far_flag,
//                                          out_range_done, out_distance_centi
//   cfg       in   cfg_wr_en               cfg_addr, cfg_wdata
//
// Each request is one tick and yields one result, registered at acceptance and valid in the cycle after.
// A new request is taken every cycle while the result register is empty or being drained.
// The count to distance multiply and far compare sit in the same cycle as the phase update.
// A stalled result holds the input side; a held result is not lost or repeated.
// Synchronous active-low reset returns to the trigger phase with stored distance zero; result register is not reset.
module ultrasonic_echo_ranger (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_echo_level,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_trigger_level,
  output logic                             out_far_flag,
  output logic                             out_range_done,
  output logic [uer_pkg::DistWidth-1:0]    out_distance_centi,
  input  logic                             cfg_wr_en,
  input  logic [uer_pkg::CfgIdxWidth-1:0]  cfg_addr,
  input  logic [uer_pkg::CfgDataWidth-1:0] cfg_wdata
);

  uer_pkg::uer_cfg_t             cfg;
  uer_pkg::uer_ctrl_t            ctrl;
  logic                          step;
  logic [uer_pkg::DistWidth-1:0] dist_nxt;
  logic                          far_nxt;

  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic                          trig_r;
  logic                          far_r;
  logic                          done_r;
  logic [uer_pkg::DistWidth-1:0] dist_r;

  assign in_ready = !out_valid_r || out_ready;
  assign step     = in_valid && in_ready;

  uer_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  uer_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .echo          (in_echo_level),
    .trigger_ticks (cfg.trigger_ticks),
    .hold_ticks    (cfg.hold_ticks),
    .ctrl_o        (ctrl)
  );

  uer_conv u_conv (
    .clk                 (clk),
    .rst_n               (rst_n),
    .step                (step),
    .ctrl_i              (ctrl),
    .scale_q16           (cfg.scale_q16),
    .far_threshold_centi (cfg.far_threshold_centi),
    .dist_nxt            (dist_nxt),
    .far_nxt             (far_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      trig_r <= ctrl.trig;
      far_r  <= far_nxt;
      done_r <= ctrl.done;
      dist_r <= dist_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_trigger_level  = trig_r;
  assign out_far_flag       = far_r;
  assign out_range_done     = done_r;
  assign out_distance_centi = dist_r;

endmodule
